FILE: hdl/byte_frame_deframer_xor_check_defines.svh
// Assertion macros shared by the deframer modules.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef BYTE_FRAME_DEFRAMER_XOR_CHECK_DEFINES_SVH
`define BYTE_FRAME_DEFRAMER_XOR_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFDX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFDX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bfdx_pkg.sv
package bfdx_pkg;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int EVENT_W = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [BYTE_W-1:0] START_MARKER_RESET  = 8'hAA;
   localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT_RESET = 16'd256;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_LIMIT = 1'd1;

   // Parser phases
   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEN_LO  = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_TYPE    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5
   } bfdx_phase_type;

   // Result events
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 3'd0,
      EV_BYTE   = 3'd1,
      EV_GOOD   = 3'd2,
      EV_BADSUM = 3'd3,
      EV_BADLEN = 3'd4
   } bfdx_event_type;

   // Configuration as seen by the parser
   typedef struct packed {
      logic [BYTE_W-1:0] start_marker;
      logic [LEN_W-1:0]  payload_limit;
   } bfdx_cfg_type;

   // One result word
   typedef struct packed {
      bfdx_event_type    event_res;
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  byte_index;
      logic [BYTE_W-1:0] frame_type;
      logic [LEN_W-1:0]  payload_length;
   } bfdx_result_type;

endpackage

FILE: hdl/bfdx_if.sv
// Received byte channel.
interface bfdx_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfdx_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface bfdx_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfdx_pkg::EVENT_W-1:0]  event_res;
   logic [bfdx_pkg::BYTE_W-1:0]   payload_byte;
   logic [bfdx_pkg::LEN_W-1:0]    byte_index;
   logic [bfdx_pkg::BYTE_W-1:0]   frame_type;
   logic [bfdx_pkg::LEN_W-1:0]    payload_length;

   modport source (output valid, output event_res, output payload_byte,
                   output byte_index, output frame_type, output payload_length,
                   input ready);
   modport sink   (input valid, input event_res, input payload_byte,
                   input byte_index, input frame_type, input payload_length,
                   output ready);
endinterface

FILE: hdl/bfdx_csr.sv
module bfdx_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bfdx_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfdx_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bfdx_pkg::bfdx_cfg_type           cfg
);
   import bfdx_pkg::*;

   logic [BYTE_W-1:0] start_marker_ff, start_marker_in;
   logic [LEN_W-1:0]  payload_limit_ff, payload_limit_in;

   // Register write decode.
   always_comb begin
      start_marker_in  = start_marker_ff;
      payload_limit_in = payload_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER:  start_marker_in  = csr_wdata[BYTE_W-1:0];
            CSR_PAYLOAD_LIMIT: payload_limit_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff  <= START_MARKER_RESET;
         payload_limit_ff <= PAYLOAD_LIMIT_RESET;
      end else begin
         start_marker_ff  <= start_marker_in;
         payload_limit_ff <= payload_limit_in;
      end
   end

   assign cfg.start_marker  = start_marker_ff;
   assign cfg.payload_limit = payload_limit_ff;

endmodule

FILE: hdl/bfdx_parser.sv
module bfdx_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [bfdx_pkg::BYTE_W-1:0]   rx_byte,
   input  bfdx_pkg::bfdx_cfg_type        cfg,
   output bfdx_pkg::bfdx_result_type     result
);
   import bfdx_pkg::*;
   `include "byte_frame_deframer_xor_check_defines.svh"

   bfdx_phase_type    phase_ff, phase_in;
   logic [LEN_W-1:0]  decl_len_ff, decl_len_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] run_xor_ff, run_xor_in;
   logic [BYTE_W-1:0] held_type_ff, held_type_in;

   logic [LEN_W-1:0]  full_len;
   logic              len_bad;
   logic              last_payload;
   logic [LEN_W:0]    count_inc;
   logic [LEN_W:0]    decl_wide;

   // Length assembled from the held low byte and the incoming high byte.
   assign full_len = {rx_byte, decl_len_ff[BYTE_W-1:0]};
   assign len_bad  = (full_len == '0) ||
                     ({1'b0, full_len} > ({1'b0, cfg.payload_limit} + 17'd1));

   // The current byte is the last payload byte once count plus two reaches the length.
   assign last_payload = (({1'b0, count_ff} + 17'd2) >= {1'b0, decl_len_ff});

   // Widened count and length for the consistency checks.
   assign count_inc = {1'b0, count_ff} + 17'd1;
   assign decl_wide = {1'b0, decl_len_ff};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_LEN_LO:  phase_in = PH_LEN_HI;
         PH_LEN_HI:  phase_in = len_bad ? PH_IDLE : PH_TYPE;
         PH_TYPE:    phase_in = (decl_len_ff == 16'd1) ? PH_CHECK : PH_PAYLOAD;
         PH_PAYLOAD: phase_in = last_payload ? PH_CHECK : PH_PAYLOAD;
         PH_CHECK:   phase_in = PH_IDLE;
         default:    phase_in = (rx_byte == cfg.start_marker) ? PH_LEN_LO : PH_IDLE;
      endcase
   end

   // Datapath updates and the result word.
   always_comb begin
      decl_len_in  = decl_len_ff;
      count_in     = count_ff;
      run_xor_in   = run_xor_ff;
      held_type_in = held_type_ff;
      result       = '0;
      result.event_res = EV_NONE;
      unique case (phase_ff)
         PH_LEN_LO: begin
            decl_len_in = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
            run_xor_in  = rx_byte;
         end
         PH_LEN_HI: begin
            decl_len_in = full_len;
            run_xor_in  = run_xor_ff ^ rx_byte;
            if (len_bad) begin
               result.event_res = EV_BADLEN;
            end
         end
         PH_TYPE: begin
            held_type_in = rx_byte;
            run_xor_in   = run_xor_ff ^ rx_byte;
            count_in     = '0;
         end
         PH_PAYLOAD: begin
            result.event_res    = EV_BYTE;
            result.payload_byte = rx_byte;
            result.byte_index   = count_ff;
            run_xor_in          = run_xor_ff ^ rx_byte;
            count_in            = count_ff + 16'd1;
         end
         PH_CHECK: begin
            result.event_res      = (rx_byte == run_xor_ff) ? EV_GOOD : EV_BADSUM;
            result.frame_type     = held_type_ff;
            result.payload_length = count_ff;
         end
         default: begin
            if (rx_byte == cfg.start_marker) begin
               decl_len_in  = '0;
               count_in     = '0;
               run_xor_in   = '0;
               held_type_in = '0;
            end
         end
      endcase
   end

   // State advances only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         decl_len_ff  <= '0;
         count_ff     <= '0;
         run_xor_ff   <= '0;
         held_type_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         decl_len_ff  <= decl_len_in;
         count_ff     <= count_in;
         run_xor_ff   <= run_xor_in;
         held_type_ff <= held_type_in;
      end
   end

   // Counter and declared length must stay consistent within a frame.
   `BFDX_ASSERT_NOW(a_payload_count, phase_ff == PH_PAYLOAD, count_inc < decl_wide, "count ran over")
   `BFDX_ASSERT_NOW(a_check_count, phase_ff == PH_CHECK, count_inc == decl_wide, "bad final count")
   `BFDX_ASSERT_NEXT(a_reject_idle, accept && len_bad && phase_ff == PH_LEN_HI, phase_ff == PH_IDLE, "not idle")

endmodule

FILE: hdl/bfdx_out_reg.sv
module bfdx_out_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  bfdx_pkg::bfdx_result_type  in_result,
   bfdx_rsp_if.source                 rsp_if
);
   import bfdx_pkg::*;
   `include "byte_frame_deframer_xor_check_defines.svh"

   logic            valid_ff, valid_in;
   bfdx_result_type data_ff, data_in;
   logic            in_fire;

   // The register takes a new word whenever it is empty or being drained.
   assign in_ready = !valid_ff || rsp_if.ready;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_fire) begin
         valid_in = 1'b1;
         data_in  = in_result;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.event_res      = data_ff.event_res;
   assign rsp_if.payload_byte   = data_ff.payload_byte;
   assign rsp_if.byte_index     = data_ff.byte_index;
   assign rsp_if.frame_type     = data_ff.frame_type;
   assign rsp_if.payload_length = data_ff.payload_length;

   // Every accepted word is presented in the following cycle.
   `BFDX_ASSERT_NEXT(a_result_follows, in_fire, valid_ff, "accepted word produced no result")
   `BFDX_ASSERT_NEXT(a_result_held, valid_ff && !rsp_if.ready, valid_ff && (data_ff == $past(data_ff)), "stalled result lost or changed")

endmodule

FILE: hdl/byte_frame_deframer_xor_check.sv
// Channel   Direction  Contents
// req_if    in         one received byte per word
// rsp_if    out        one result word per received byte
// csr_*     in         start marker and maximum payload writes
//
// Each received byte's result is registered and appears in the cycle after the byte is accepted.
// A new byte can be accepted every cycle, limited only by the output register.
// The output register accepts while empty or while its word is being taken.
// Reset is synchronous and returns the parser to idle with default registers.
module byte_frame_deframer_xor_check (
   input  logic                             clock,
   input  logic                             reset,
   bfdx_req_if.sink                         req_if,
   bfdx_rsp_if.source                       rsp_if,
   input  logic                             csr_we,
   input  logic [bfdx_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfdx_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bfdx_pkg::*;

   bfdx_cfg_type    cfg;
   bfdx_result_type result;
   logic            out_ready;
   logic            req_fire;

   assign req_if.ready = out_ready;
   assign req_fire     = req_if.valid && out_ready;

   // Configuration registers.
   bfdx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Frame parser.
   bfdx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_fire),
      .rx_byte (req_if.rx_byte),
      .cfg     (cfg),
      .result  (result)
   );

   // Result register.
   bfdx_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (out_ready),
      .in_result (result),
      .rsp_if    (rsp_if)
   );

endmodule
